// File: rtl/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size class block allocator
// Widths, operation and status codes, and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

  // pool geometry
  localparam int POOL_DEPTH       = 256;
  localparam int BASE_BLOCK_BYTES = 8;
  localparam int NUM_CLASSES      = 4;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int SIZE_W   = 7;
  localparam int IDX_W    = 11;
  localparam int STATUS_W = 3;
  localparam int BLK_W    = 10;
  localparam int CLS_W    = 2;
  localparam int OFF_W    = 14;
  localparam int COUNT_W  = 9;
  localparam int CFG_IDX_W = 3;

  // derived widths
  localparam int LOCAL_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int TOP_W   = $clog2(POOL_DEPTH + 1);
  localparam int SUM_W   = (TOP_W + 2 > IDX_W) ? TOP_W + 2 : IDX_W;
  localparam int ADDR_W  = $clog2(NUM_CLASSES * POOL_DEPTH);
  localparam int BYTES_W = $clog2(BASE_BLOCK_BYTES * 8 + 1);
  localparam int PROD_W  = BYTES_W + LOCAL_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(256);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_GET   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // decoded request, from the decoder to the stack and the pipeline
  typedef struct packed {
    logic                pop;
    logic                push;
    logic                get;
    status_t             status;
    logic [CLS_W-1:0]    cls;
    logic [LOCAL_W-1:0]  local_idx;
    logic [SUM_W-1:0]    base;
  } dec_t;

  // stack condition of the addressed class
  typedef struct packed {
    logic empty;
    logic full;
  } stack_flags_t;

  // refill command on a count register write
  typedef struct packed {
    logic             valid;
    logic [CLS_W-1:0] cls;
    logic [TOP_W-1:0] n;
  } refill_t;

  // block count clipped to the pool depth
  function automatic logic [TOP_W-1:0] eff_count(input logic [COUNT_W-1:0] n);
    logic [TOP_W-1:0] r;
    if (32'(n) > POOL_DEPTH) r = TOP_W'(POOL_DEPTH);
    else                     r = TOP_W'(n);
    return r;
  endfunction

  // bytes per block of a class
  function automatic logic [BYTES_W-1:0] block_bytes(input logic [CLS_W-1:0] c);
    return BYTES_W'(BASE_BLOCK_BYTES) << c;
  endfunction

  // stack memory address of a class and position
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLS_W-1:0] c,
                                                 input logic [TOP_W-1:0] pos);
    return ADDR_W'(c) * ADDR_W'(POOL_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

`default_nettype wire

// File: rtl/scba_if.sv
// ----------------------------------------------------------------------------
// scba_if: request and response channels of the allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface scba_req_if import scba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [SIZE_W-1:0]  req_size;
  logic [IDX_W-1:0]   index;

  modport source(output valid, func, req_size, index, input ready);
  modport sink(input valid, func, req_size, index, output ready);
endinterface

interface scba_rsp_if import scba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BLK_W-1:0]    block_index;
  logic [CLS_W-1:0]    size_class;
  logic [OFF_W-1:0]    byte_offset;

  modport source(output valid, status, block_index, size_class, byte_offset,
                 input ready);
  modport sink(input valid, status, block_index, size_class, byte_offset,
               output ready);
endinterface

`default_nettype wire

// File: rtl/scba_decode.sv
// ----------------------------------------------------------------------------
// scba_decode: request decoder
// Maps an alloc size to its class and a global index to class and local
// index, using the cumulative class region bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_decode import scba_pkg::*; (
  input  logic [FUNC_W-1:0]  func,
  input  logic [SIZE_W-1:0]  req_size,
  input  logic [IDX_W-1:0]   index,
  input  logic [COUNT_W-1:0] counts [NUM_CLASSES],
  output dec_t               dec
);

  logic [SUM_W-1:0] ends  [NUM_CLASSES];
  logic [SUM_W-1:0] bases [NUM_CLASSES];
  logic [CLS_W-1:0] alloc_cls;
  logic             size_bad;
  logic [CLS_W-1:0] hit_cls;
  logic             hit;
  logic [SUM_W-1:0] idx_ext;

  // region bounds of each class
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (c == 0) bases[c] = '0;
      else        bases[c] = ends[c-1];
      ends[c] = bases[c] + SUM_W'(eff_count(counts[c]));
    end
  end

  // smallest class that holds the request
  always_comb begin
    size_bad  = 32'(req_size) > 32'(block_bytes(CLS_W'(NUM_CLASSES - 1)));
    alloc_cls = CLS_W'(NUM_CLASSES - 1);
    for (int c = NUM_CLASSES - 2; c >= 0; c--) begin
      if (32'(req_size) <= 32'(block_bytes(CLS_W'(c)))) alloc_cls = CLS_W'(c);
    end
  end

  // first region that contains the global index
  assign idx_ext = SUM_W'(index);
  always_comb begin
    hit     = 1'b0;
    hit_cls = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (idx_ext < ends[c]) begin
        hit     = 1'b1;
        hit_cls = CLS_W'(c);
      end
    end
  end

  // operation decode
  always_comb begin
    dec = '0;
    dec.status = ST_OK;
    case (func_t'(func))
      FUNC_ALLOC: begin
        dec.cls  = alloc_cls;
        dec.base = bases[alloc_cls];
        if (size_bad) dec.status = ST_BAD_SIZE;
        else          dec.pop    = 1'b1;
      end
      FUNC_FREE, FUNC_GET: begin
        dec.cls       = hit_cls;
        dec.base      = bases[hit_cls];
        dec.local_idx = LOCAL_W'(idx_ext - bases[hit_cls]);
        if (!hit)                            dec.status = ST_BAD_INDEX;
        else if (func_t'(func) == FUNC_FREE) dec.push   = 1'b1;
        else                                 dec.get    = 1'b1;
      end
      default: begin
        dec.status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/scba_stack.sv
// ----------------------------------------------------------------------------
// scba_stack: per-class free stacks
// Stack tops, low marks and the shared stack memory. Positions below a
// class's low mark were never written since its refill and read as their
// own position; the memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_stack import scba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               item_valid,
  input  dec_t               dec,
  input  refill_t            refill,
  input  logic [COUNT_W-1:0] counts [NUM_CLASSES],
  output stack_flags_t       flags,
  output logic [LOCAL_W-1:0] pop_local
);

  logic [TOP_W-1:0]   tops [NUM_CLASSES];
  logic [TOP_W-1:0]   lows [NUM_CLASSES];
  logic [LOCAL_W-1:0] mem  [NUM_CLASSES * POOL_DEPTH];

  logic [TOP_W-1:0]   t;
  logic [TOP_W-1:0]   lo;
  logic [TOP_W-1:0]   t_dec;
  logic               do_pop;
  logic               do_push;
  logic [LOCAL_W-1:0] rd_data;
  logic [LOCAL_W-1:0] init_val;
  logic               init_sel;

  // state of the addressed class
  assign t     = tops[dec.cls];
  assign lo    = lows[dec.cls];
  assign t_dec = t - 1'b1;

  assign flags.empty = (t == '0);
  assign flags.full  = (t >= eff_count(counts[dec.cls]));

  assign do_pop  = en && item_valid && dec.pop && !flags.empty;
  assign do_push = en && item_valid && dec.push && !flags.full;

  // tops and low marks
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        tops[c] <= eff_count(COUNT_RESET);
        lows[c] <= eff_count(COUNT_RESET);
      end
    end else if (refill.valid) begin
      tops[refill.cls] <= refill.n;
      lows[refill.cls] <= refill.n;
    end else begin
      if (do_pop) begin
        tops[dec.cls] <= t_dec;
        if (t == lo) lows[dec.cls] <= t_dec;
      end
      if (do_push) tops[dec.cls] <= t + 1'b1;
    end
  end

  // stack memory, registered read of the entry below the top
  always_ff @(posedge clk) begin
    if (do_push) mem[mem_addr(dec.cls, t)] <= dec.local_idx;
    if (en) begin
      rd_data  <= mem[mem_addr(dec.cls, t_dec)];
      init_sel <= (t == lo);
      init_val <= LOCAL_W'(t_dec);
    end
  end

  // untouched positions hold their own index
  assign pop_local = init_sel ? init_val : rd_data;

`ifndef SYNTH
  a_low_not_above_top: assert property (@(posedge clk) disable iff (rst)
    (lows[0] <= tops[0]) && (lows[1] <= tops[1]) &&
    (lows[2] <= tops[2]) && (lows[3] <= tops[3]))
    else $error("low mark above stack top");

  a_top_within_count: assert property (@(posedge clk) disable iff (rst)
    (tops[0] <= eff_count(counts[0])) && (tops[1] <= eff_count(counts[1])) &&
    (tops[2] <= eff_count(counts[2])) && (tops[3] <= eff_count(counts[3])))
    else $error("stack top above class count");

  a_pop_moves_top: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !refill.valid) |=> (tops[$past(dec.cls)] == $past(t_dec)))
    else $error("pop did not lower the stack top by one");
`endif

endmodule

`default_nettype wire

// File: rtl/size_class_block_allocator.sv
// a request beat passes the request register and the stack access stage to the response register
// throughput: one request per cycle; a stalled response holds the whole pipeline
// the stack memory is read at one address and written at one address per cycle
// reset: rst clears all valids, sets every count to 256 and refills all stacks
// at once through the tops and low marks; there is no clearing pass
// ----------------------------------------------------------------------------
// size_class_block_allocator: segregated free list block allocator
// Four size classes, each with a free stack of local block indices; alloc,
// free and get requests answered through a three-register pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator import scba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data,
  scba_req_if.sink             req,
  scba_rsp_if.source           rsp
);

  logic [COUNT_W-1:0] counts [NUM_CLASSES];
  refill_t            refill;
  logic               en;

  logic               s1_valid;
  logic [FUNC_W-1:0]  s1_func;
  logic [SIZE_W-1:0]  s1_size;
  logic [IDX_W-1:0]   s1_index;

  dec_t               dec;
  stack_flags_t       flags;
  status_t            s1_status;
  logic [LOCAL_W-1:0] pop_local;

  logic               s2_valid;
  status_t            s2_status;
  logic               s2_pop_ok;
  logic               s2_get_ok;
  logic [CLS_W-1:0]   s2_cls;
  logic [SUM_W-1:0]   s2_base;
  logic [LOCAL_W-1:0] s2_local;

  logic [LOCAL_W-1:0] s2_loc;
  logic [SUM_W-1:0]   s2_sum;
  logic [PROD_W-1:0]  s2_prod;

  logic               out_valid;
  status_t            out_status;
  logic [BLK_W-1:0]   out_blk;
  logic [CLS_W-1:0]   out_cls;
  logic [OFF_W-1:0]   out_off;

  // pipeline advances unless a response beat waits
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  // count registers
  assign refill.valid = cfg_we && (cfg_index < CFG_IDX_W'(NUM_CLASSES));
  assign refill.cls   = CLS_W'(cfg_index);
  assign refill.n     = eff_count(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) counts[c] <= COUNT_RESET;
    end else if (refill.valid) begin
      counts[refill.cls] <= cfg_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= req.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_func  <= req.func;
      s1_size  <= req.req_size;
      s1_index <= req.index;
    end
  end

  scba_decode u_decode (
    .func     (s1_func),
    .req_size (s1_size),
    .index    (s1_index),
    .counts   (counts),
    .dec      (dec)
  );

  scba_stack u_stack (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (s1_valid),
    .dec        (dec),
    .refill     (refill),
    .counts     (counts),
    .flags      (flags),
    .pop_local  (pop_local)
  );

  // final status of the request
  always_comb begin
    s1_status = dec.status;
    if (dec.pop && flags.empty)      s1_status = ST_EMPTY;
    else if (dec.push && flags.full) s1_status = ST_FULL;
  end

  // stack access stage
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_status <= s1_status;
      s2_pop_ok <= dec.pop && !flags.empty;
      s2_get_ok <= dec.get;
      s2_cls    <= dec.cls;
      s2_base   <= dec.base;
      s2_local  <= dec.local_idx;
    end
  end

  // global index and byte offset
  assign s2_loc  = s2_pop_ok ? pop_local : s2_local;
  assign s2_sum  = s2_base + SUM_W'(s2_loc);
  assign s2_prod = PROD_W'(block_bytes(s2_cls)) * PROD_W'(s2_loc);

  // response register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status <= s2_status;
      out_blk    <= s2_pop_ok ? BLK_W'(s2_sum) : '0;
      out_cls    <= (s2_pop_ok || s2_get_ok) ? s2_cls : '0;
      out_off    <= (s2_pop_ok || s2_get_ok) ? OFF_W'(s2_prod) : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.block_index = out_blk;
  assign rsp.size_class  = out_cls;
  assign rsp.byte_offset = out_off;

`ifndef SYNTH
  a_ok_pop_status: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_pop_ok) |-> (s2_status == ST_OK))
    else $error("granted block with an error status");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |->
    ((out_blk == '0) && (out_cls == '0) && (out_off == '0)))
    else $error("error response carries nonzero fields");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    (!en && s1_valid) |=> s1_valid && $stable(s1_index) && $stable(s1_func))
    else $error("request stage changed during a stall");
`endif

endmodule

`default_nettype wire
